### src/adsr_envelope_generator_defines.svh
// Assertion macros for the ADSR envelope generator.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every clock edge outside reset.
`define ADSR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ADSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ADSR_ASSERT(label, ante, cons, msg)
`define ADSR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### src/adsr_pkg.sv
// Shared types, constants and helpers for the ADSR envelope generator.
package adsr_pkg;

  localparam int DEF_COUNT_BITS = 24;
  localparam int DEF_FRAC_BITS  = 24;

  localparam int LEVEL_W   = 16;
  localparam int DUR_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] FULL_Q15 = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;

  localparam logic [DUR_W-1:0]   RST_ATTACK  = 24'd480;
  localparam logic [DUR_W-1:0]   RST_DECAY   = 24'd4800;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd16384;
  localparam logic [DUR_W-1:0]   RST_RELEASE = 24'd4800;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_TRIG_ON   = 2'd1,
    CMD_TRIG_OFF  = 2'd2,
    CMD_SET_LEVEL = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    RS_ATTACK  = 2'd0,
    RS_DECAY   = 2'd1,
    RS_RELEASE = 2'd2
  } ramp_sel_t;

  typedef enum logic [2:0] {
    S_IDLE       = 3'd0,
    S_TICK_CHECK = 3'd1,
    S_TICK_WAIT  = 3'd2,
    S_OUT        = 3'd3,
    S_RAMP_WAIT  = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic      step_en;
    logic      ramp_start;
    ramp_sel_t ramp_sel;
    logic      set_level;
    logic      phase_load;
    phase_t    phase_val;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic   left_zero;
    phase_t phase;
    logic   ramp_busy;
    logic   out_free;
  } dp_status_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > FULL_Q15) ? FULL_Q15 : v;
  endfunction

endpackage

### src/adsr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module adsr_div #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR_W  = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvsr;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // partial remainder stays below the divisor, so the shifted value is below twice it
  always_comb begin
    shifted = {rem, quotient[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvsr};
    fits    = !diff[DIVISOR_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

### src/adsr_datapath.sv
// Envelope datapath: config registers, level accumulator, ramp setup and output word.
module adsr_datapath #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsr_pkg::DUR_W-1:0]        cfg_data,
  input  logic [adsr_pkg::LEVEL_W-1:0]      new_level,
  input  adsr_pkg::dp_cmd_t                 cmd,
  output adsr_pkg::dp_status_t              status,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [adsr_pkg::LEVEL_W-1:0]      sample_level,
  output logic [2:0]                        phase
);
  import adsr_pkg::*;

  localparam int ACC_W  = LEVEL_W + FRAC_BITS;
  localparam int STEP_W = ACC_W + 1;
  localparam int SUM_W  = ACC_W + 2;

  localparam logic [ACC_W-1:0] FULL_ACC = {1'b1, {(ACC_W-1){1'b0}}};

  logic [DUR_W-1:0]   attack_samples;
  logic [DUR_W-1:0]   decay_samples;
  logic [LEVEL_W-1:0] sustain_level;
  logic [DUR_W-1:0]   release_samples;

  logic [ACC_W-1:0]         acc;
  logic signed [STEP_W-1:0] step;
  logic [COUNT_BITS-1:0]    samples_left;
  phase_t                   cur_phase;
  logic                     ramp_pending;
  logic                     ramp_neg;
  phase_t                   out_phase;

  logic [COUNT_BITS-1:0]    ramp_n;
  logic [ACC_W-1:0]         ramp_target;
  logic [ACC_W-1:0]         ramp_mag;
  logic                     ramp_down;
  logic                     div_start;
  logic                     div_done;
  logic [ACC_W-1:0]         div_quo;
  logic signed [STEP_W-1:0] step_mag;
  logic signed [SUM_W-1:0]  sum;
  logic [ACC_W-1:0]         acc_sat;

  always_comb begin
    unique case (cmd.ramp_sel)
      RS_ATTACK: begin
        ramp_n      = COUNT_BITS'(attack_samples);
        ramp_target = FULL_ACC;
      end
      RS_DECAY: begin
        ramp_n      = COUNT_BITS'(decay_samples);
        ramp_target = {clamp_level(sustain_level), {FRAC_BITS{1'b0}}};
      end
      default: begin
        ramp_n      = COUNT_BITS'(release_samples);
        ramp_target = '0;
      end
    endcase
    ramp_down = ramp_target < acc;
    ramp_mag  = ramp_down ? (acc - ramp_target) : (ramp_target - acc);
    div_start = cmd.ramp_start && (ramp_n != '0);
  end

  adsr_div #(
    .DIVIDEND_W(ACC_W),
    .DIVISOR_W (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(ramp_mag),
    .divisor (ramp_n),
    .done    (div_done),
    .quotient(div_quo)
  );

  // one tick: signed add, then clamp to 0 .. full scale
  always_comb begin
    step_mag = $signed({1'b0, div_quo});
    sum      = $signed({2'b00, acc}) + $signed({step[STEP_W-1], step});
    if (sum[SUM_W-1]) begin
      acc_sat = '0;
    end else if (sum[SUM_W-2:0] > {1'b0, FULL_ACC}) begin
      acc_sat = FULL_ACC;
    end else begin
      acc_sat = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= RST_ATTACK;
      decay_samples   <= RST_DECAY;
      sustain_level   <= RST_SUSTAIN;
      release_samples <= RST_RELEASE;
      acc             <= '0;
      step            <= '0;
      samples_left    <= '0;
      cur_phase       <= PH_OFF;
      ramp_pending    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATTACK:  attack_samples  <= cfg_data;
          CFG_DECAY:   decay_samples   <= cfg_data;
          CFG_SUSTAIN: sustain_level   <= cfg_data[LEVEL_W-1:0];
          CFG_RELEASE: release_samples <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.set_level) begin
        acc          <= {clamp_level(new_level), {FRAC_BITS{1'b0}}};
        step         <= '0;
        samples_left <= '0;
      end
      if (cmd.step_en && (samples_left != '0)) begin
        samples_left <= samples_left - 1'b1;
        acc          <= acc_sat;
      end
      if (cmd.ramp_start) begin
        samples_left <= ramp_n;
        unique case (cmd.ramp_sel)
          RS_ATTACK: cur_phase <= PH_ATTACK;
          RS_DECAY:  cur_phase <= PH_DECAY;
          default:   cur_phase <= PH_RELEASE;
        endcase
        if (ramp_n == '0) begin
          step <= '0;
        end else begin
          ramp_pending <= 1'b1;
        end
      end
      if (cmd.phase_load) begin
        cur_phase <= cmd.phase_val;
      end
      if (div_done) begin
        ramp_pending <= 1'b0;
        step         <= ramp_neg ? -step_mag : step_mag;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      ramp_neg <= ramp_down;
    end
    if (cmd.out_load) begin
      sample_level <= acc[FRAC_BITS +: LEVEL_W];
      out_phase    <= cur_phase;
    end
  end

  assign phase = out_phase;

  always_comb begin
    status.left_zero = (samples_left == '0);
    status.phase     = cur_phase;
    status.ramp_busy = ramp_pending;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

### src/adsr_ctrl.sv
// Envelope controller: sequences each command word through the datapath.
module adsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           command,
  output logic                 in_stall,
  input  adsr_pkg::dp_status_t status,
  output adsr_pkg::dp_cmd_t    cmd
);
  import adsr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (cmd_code_t'(command))
            CMD_TICK: begin
              cmd.step_en = 1'b1;
              state_next  = S_TICK_CHECK;
            end
            CMD_TRIG_ON: begin
              cmd.ramp_start = 1'b1;
              cmd.ramp_sel   = RS_ATTACK;
              state_next     = S_RAMP_WAIT;
            end
            CMD_TRIG_OFF: begin
              cmd.ramp_start = 1'b1;
              cmd.ramp_sel   = RS_RELEASE;
              state_next     = S_RAMP_WAIT;
            end
            CMD_SET_LEVEL: begin
              cmd.set_level = 1'b1;
            end
          endcase
        end
      end
      S_TICK_CHECK: begin
        state_next = S_OUT;
        if (status.left_zero) begin
          unique case (status.phase)
            PH_ATTACK: begin
              cmd.ramp_start = 1'b1;
              cmd.ramp_sel   = RS_DECAY;
              state_next     = S_TICK_WAIT;
            end
            PH_DECAY: begin
              cmd.phase_load = 1'b1;
              cmd.phase_val  = PH_SUSTAIN;
            end
            PH_RELEASE: begin
              cmd.phase_load = 1'b1;
              cmd.phase_val  = PH_OFF;
            end
            default: ;
          endcase
        end
      end
      S_TICK_WAIT: begin
        if (!status.ramp_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RAMP_WAIT: begin
        if (!status.ramp_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### src/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator.
// Input channel: in_valid/in_stall carry one command word (command, new_level).
//   Commands: tick, trigger on, trigger off, set level. A word is taken when
//   in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall carry one result word (sample_level,
//   phase) for every tick; the other commands give no word.
// Config: cfg_we writes cfg_data to register cfg_index (attack, decay,
//   sustain, release); indexes beyond 3 are dropped. Write only while idle.
// Sequence, set by the controller and the bit-serial step divider:
//   tick: step, phase check, result load; input held off until the load.
//   tick that ends the attack: the decay-step divide runs after the phase
//   check, before the result load (no divide if the decay duration is zero).
//   trigger on / off: one divide (none if the duration is zero).
//   set level: taken in idle; input is not held off.
// A finished result sits in the output register while the next word is taken;
// if out_stall holds it, the next tick waits for the register to drain.
// Reset (rst, synchronous): config back to defaults, level 0, phase off,
// no result pending.
module adsr_envelope_generator #(
  parameter int COUNT_BITS = adsr_pkg::DEF_COUNT_BITS,
  parameter int FRAC_BITS  = adsr_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adsr_pkg::DUR_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     command,
  input  logic [adsr_pkg::LEVEL_W-1:0]   new_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [adsr_pkg::LEVEL_W-1:0]   sample_level,
  output logic [2:0]                     phase
);
  import adsr_pkg::*;

`include "adsr_envelope_generator_defines.svh"

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       tick_taken;

  // controller: one word at a time, stalls input while busy
  adsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .command (command),
    .in_stall(in_stall),
    .status  (dp_status),
    .cmd     (dp_cmd)
  );

  // datapath: accumulator, step divider, output register
  adsr_datapath #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .new_level   (new_level),
    .cmd         (dp_cmd),
    .status      (dp_status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .sample_level(sample_level),
    .phase       (phase)
  );

  assign tick_taken = in_valid && !in_stall && (command == CMD_TICK);

  // a step divide only runs while the controller holds off input
  `ADSR_ASSERT(a_ramp_while_busy, dp_status.ramp_busy, in_stall, "ramp divide while idle")
  // never load the output register over an untaken word
  `ADSR_ASSERT(a_no_overwrite, dp_cmd.out_load, dp_status.out_free, "result word overwritten")
  // saturation keeps the reported level within full scale
  `ADSR_ASSERT(a_level_range, out_valid, sample_level <= FULL_Q15, "level above full scale")
  // an accepted tick always keeps the block busy for its result
  `ADSR_ASSERT_NXT(a_tick_busy, tick_taken, in_stall, "tick not sequenced")

endmodule
